// ===== rtl/ira_pkg.sv =====
// Shared constants, types and helper functions of the image rotate resampler.
package ira_pkg;

  localparam int MAX_SIDE    = 256;
  localparam int SIDE_BITS   = $clog2(MAX_SIDE);
  localparam int ADDR_BITS   = 2 * SIDE_BITS;
  localparam int MAX_FACTOR  = 8;
  localparam int PIXEL_BITS  = 16;
  localparam int DIV_BITS    = 24;
  localparam int RECIP_SHIFT = 20;

  typedef enum logic [2:0] {
    CFG_SOURCE_WIDTH  = 3'd0,
    CFG_SOURCE_HEIGHT = 3'd1,
    CFG_SINE          = 3'd2,
    CFG_COSINE        = 3'd3,
    CFG_UPSAMPLE      = 3'd4,
    CFG_DOWNSAMPLE    = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [8:0]         src_w;
    logic [8:0]         src_h;
    logic signed [16:0] sine;
    logic [16:0]        cosine;
    logic [3:0]         up;
    logic [3:0]         down;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_GEO0,
    OP_GEO1,
    OP_GEO2,
    OP_DIVW,
    OP_DIVH,
    OP_CHECK,
    OP_INIT,
    OP_MUL,
    OP_XY,
    OP_SDIV,
    OP_ACC,
    OP_DIVM,
    OP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    logic div_done;
    logic fetch_ok;
    logic last_sample;
    logic out_free;
  } dp_stat_t;

  typedef enum logic [1:0] {
    SEL_W,
    SEL_H,
    SEL_MEAN
  } div_sel_t;

  // Round a Q16 value to an integer, away from zero unless exact.
  function automatic logic signed [23:0] round_away(input logic signed [39:0] q);
    logic signed [39:0] t;
    if (q >= 0) begin
      t = (q + 40'sd65535) >>> 16;
    end else begin
      t = -((-q + 40'sd65535) >>> 16);
    end
    return t[23:0];
  endfunction

  function automatic logic [3:0] clamp_factor(input logic [3:0] v);
    logic [3:0] r;
    if (v == 4'd0) begin
      r = 4'd1;
    end else if (v > 4'(MAX_FACTOR)) begin
      r = 4'(MAX_FACTOR);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [8:0] clamp_side(input logic [8:0] v);
    logic [8:0] r;
    if (v == 9'd0) begin
      r = 9'd1;
    end else if (v > 9'(MAX_SIDE)) begin
      r = 9'(MAX_SIDE);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // ceil(2^RECIP_SHIFT / f): exact floor division of an 11-bit coordinate by f.
  function automatic logic [20:0] recip(input logic [3:0] f);
    logic [20:0] r;
    unique case (f)
      4'd2:    r = 21'd524288;
      4'd3:    r = 21'd349526;
      4'd4:    r = 21'd262144;
      4'd5:    r = 21'd209716;
      4'd6:    r = 21'd174763;
      4'd7:    r = 21'd149797;
      4'd8:    r = 21'd131072;
      default: r = 21'd1048576;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/ira_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ira_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ira_div.sv =====
// Restoring divider, one quotient bit per cycle.
module ira_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ira_pkg::DIV_BITS-1:0] dividend,
  input  logic [6:0]                   divisor,
  output logic                         done,
  output logic [ira_pkg::DIV_BITS-1:0] quotient
);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [4:0]                   cnt_r, cnt_nxt;
  logic [7:0]                   rem_r, rem_nxt;
  logic [ira_pkg::DIV_BITS-1:0] quo_r, quo_nxt;
  logic [6:0]                   dvs_r, dvs_nxt;
  logic [7:0]                   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r[6:0], quo_r[ira_pkg::DIV_BITS-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
      rem_nxt  = 8'd0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[ira_pkg::DIV_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[ira_pkg::DIV_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(ira_pkg::DIV_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/ira_dp.sv =====
// Datapath: geometry, rotated sample addressing, box sum, mean and output register.
module ira_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ira_pkg::dp_op_t                op,
  output ira_pkg::dp_stat_t              stat,
  input  ira_pkg::cfg_t                  cfg,
  input  logic                           in_accept,
  input  logic [12:0]                    fetch_col,
  input  logic [12:0]                    fetch_row,
  input  logic [ira_pkg::PIXEL_BITS-1:0] ram_rdata,
  output logic [ira_pkg::ADDR_BITS-1:0]  ram_raddr,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [15:0]                    out_pixel,
  output logic                           out_in_range,
  output logic [12:0]                    out_width,
  output logic [12:0]                    out_height
);

  localparam int SB = ira_pkg::SIDE_BITS;

  logic [12:0] fc_r, fr_r;
  logic [3:0]  up_r, d_r;
  logic [12:0] w_r, h_r;
  logic [6:0]  dd_r;
  logic signed [35:0] p_hs_r, p_wc_r, p_hc_r, p_ws_r;
  logic signed [15:0] umin_r, vmin_r;
  logic [14:0] npu_r, npv_r, ow_r, oh_r;
  logic signed [17:0] ubase_r, vbase_r;
  logic [2:0]  i_r, j_r;
  logic signed [35:0] puc_r, pvs_r, pus_r, pvc_r;
  logic [10:0] x_r, y_r;
  logic        hit_r;
  logic [SB-1:0] sx_r, sy_r;
  logic signed [23:0] sum_r;
  logic        neg_r;
  logic        valid_r;
  logic signed [15:0] mean_r;
  ira_pkg::div_sel_t sel_r;
  logic        ov_r;
  logic [15:0] opix_r;
  logic        orng_r;
  logic [12:0] ow_out_r, oh_out_r;

  logic [8:0]  sw, sh;
  logic [3:0]  upc, dc;
  logic signed [17:0] s18, c18, u18, v18, w18, h18;
  logic signed [23:0] umin_n, vmin_n, umax_n, vmax_n, npu_n, npv_n;
  logic signed [23:0] x_n, y_n;
  logic [31:0] mx, my;
  logic [16:0] dfc, dfr;
  logic [2:0]  dm1;
  logic        div_start, div_done;
  logic [ira_pkg::DIV_BITS-1:0] div_dvd, div_quo;
  logic [6:0]  div_dvs;
  logic [23:0] sum_mag;
  logic signed [23:0] qsigned;

  assign sw  = ira_pkg::clamp_side(cfg.src_w);
  assign sh  = ira_pkg::clamp_side(cfg.src_h);
  assign upc = ira_pkg::clamp_factor(cfg.up);
  assign dc  = ira_pkg::clamp_factor(cfg.down);
  assign s18 = 18'(cfg.sine);
  assign c18 = signed'({1'b0, cfg.cosine});
  assign w18 = signed'({5'b0, w_r});
  assign h18 = signed'({5'b0, h_r});
  assign u18 = ubase_r + signed'({15'b0, i_r});
  assign v18 = vbase_r + signed'({15'b0, j_r});
  assign dfc = 17'(d_r) * 17'(fc_r);
  assign dfr = 17'(d_r) * 17'(fr_r);
  assign dm1 = 3'(d_r - 4'd1);

  // Bounding box of the rotated, stretched image.
  always_comb begin
    if (cfg.sine > 0) begin
      umin_n = 24'sd0;
      vmin_n = ira_pkg::round_away(-40'(p_ws_r));
      umax_n = ira_pkg::round_away(40'(p_hs_r) + 40'(p_wc_r));
      vmax_n = ira_pkg::round_away(40'(p_hc_r));
    end else begin
      vmin_n = 24'sd0;
      umin_n = ira_pkg::round_away(40'(p_hs_r));
      vmax_n = ira_pkg::round_away(40'(p_hc_r) - 40'(p_ws_r));
      umax_n = ira_pkg::round_away(40'(p_wc_r));
    end
    npu_n = umax_n - umin_n;
    npv_n = vmax_n - vmin_n;
  end

  assign x_n = ira_pkg::round_away(40'(puc_r) - 40'(pvs_r));
  assign y_n = ira_pkg::round_away(40'(pus_r) + 40'(pvc_r));
  assign mx  = 32'(x_r) * 32'(ira_pkg::recip(up_r));
  assign my  = 32'(y_r) * 32'(ira_pkg::recip(up_r));

  assign ram_raddr = {sy_r, sx_r};
  assign sum_mag   = sum_r[23] ? 24'(-sum_r) : 24'(sum_r);
  assign qsigned   = neg_r ? -signed'(div_quo) : signed'(div_quo);

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = {3'b0, d_r};
    unique case (op)
      ira_pkg::OP_DIVW: begin
        div_start = 1'b1;
        div_dvd   = ira_pkg::DIV_BITS'(npu_r);
      end
      ira_pkg::OP_DIVH: begin
        div_start = 1'b1;
        div_dvd   = ira_pkg::DIV_BITS'(npv_r);
      end
      ira_pkg::OP_DIVM: begin
        div_start = 1'b1;
        div_dvd   = sum_mag;
        div_dvs   = dd_r;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  ira_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (in_accept) begin
      fc_r <= fetch_col;
      fr_r <= fetch_row;
    end
    unique case (op)
      ira_pkg::OP_GEO0: begin
        up_r <= upc;
        d_r  <= dc;
        w_r  <= 13'(sw) * 13'(upc);
        h_r  <= 13'(sh) * 13'(upc);
        dd_r <= 7'(dc) * 7'(dc);
      end
      ira_pkg::OP_GEO1: begin
        p_hs_r <= 36'(h18) * 36'(s18);
        p_wc_r <= 36'(w18) * 36'(c18);
        p_hc_r <= 36'(h18) * 36'(c18);
        p_ws_r <= 36'(w18) * 36'(s18);
      end
      ira_pkg::OP_GEO2: begin
        umin_r <= umin_n[15:0];
        vmin_r <= vmin_n[15:0];
        npu_r  <= npu_n[23] ? 15'd0 : npu_n[14:0];
        npv_r  <= npv_n[23] ? 15'd0 : npv_n[14:0];
      end
      ira_pkg::OP_DIVW: sel_r <= ira_pkg::SEL_W;
      ira_pkg::OP_DIVH: sel_r <= ira_pkg::SEL_H;
      ira_pkg::OP_DIVM: begin
        sel_r <= ira_pkg::SEL_MEAN;
        neg_r <= sum_r[23];
      end
      ira_pkg::OP_CHECK: begin
        valid_r <= stat.fetch_ok;
        mean_r  <= 16'sd0;
      end
      ira_pkg::OP_INIT: begin
        ubase_r <= 18'(umin_r) + signed'({1'b0, dfc});
        vbase_r <= 18'(vmin_r) + signed'({1'b0, dfr});
        i_r     <= 3'd0;
        j_r     <= 3'd0;
        sum_r   <= 24'sd0;
      end
      ira_pkg::OP_MUL: begin
        puc_r <= 36'(u18) * 36'(c18);
        pvs_r <= 36'(v18) * 36'(s18);
        pus_r <= 36'(u18) * 36'(s18);
        pvc_r <= 36'(v18) * 36'(c18);
      end
      ira_pkg::OP_XY: begin
        x_r   <= x_n[10:0];
        y_r   <= y_n[10:0];
        hit_r <= (x_n >= 0) && (x_n < 24'(w18)) && (y_n >= 0) && (y_n < 24'(h18));
      end
      ira_pkg::OP_SDIV: begin
        sx_r <= mx[ira_pkg::RECIP_SHIFT +: SB];
        sy_r <= my[ira_pkg::RECIP_SHIFT +: SB];
      end
      ira_pkg::OP_ACC: begin
        if (hit_r) begin
          sum_r <= sum_r + 24'(signed'(ram_rdata));
        end
        if (j_r == dm1) begin
          j_r <= 3'd0;
          i_r <= i_r + 3'd1;
        end else begin
          j_r <= j_r + 3'd1;
        end
      end
      default: begin
      end
    endcase
    if (div_done) begin
      unique case (sel_r)
        ira_pkg::SEL_W:    ow_r   <= div_quo[14:0];
        ira_pkg::SEL_H:    oh_r   <= div_quo[14:0];
        default:           mean_r <= qsigned[15:0];
      endcase
    end
    if (op == ira_pkg::OP_PUBLISH) begin
      opix_r   <= mean_r;
      orng_r   <= valid_r;
      ow_out_r <= ow_r[12:0];
      oh_out_r <= oh_r[12:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (op == ira_pkg::OP_PUBLISH) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  assign stat.div_done    = div_done;
  assign stat.fetch_ok    = (15'(fc_r) < ow_r) && (15'(fr_r) < oh_r);
  assign stat.last_sample = (i_r == dm1) && (j_r == dm1);
  assign stat.out_free    = !ov_r || out_ready;

  assign out_valid    = ov_r;
  assign out_pixel    = opix_r;
  assign out_in_range = orng_r;
  assign out_width    = ow_out_r;
  assign out_height   = oh_out_r;

endmodule

// ===== rtl/ira_ctrl.sv =====
// Controller state machine that sequences a fetch through the datapath.
module ira_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_fetch,
  output logic              in_ready,
  input  ira_pkg::dp_stat_t stat,
  output ira_pkg::dp_op_t   op
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_GEO0, ST_GEO1, ST_GEO2, ST_DIVW, ST_WAITW, ST_DIVH, ST_WAITH,
    ST_CHECK, ST_INIT, ST_MUL, ST_XY, ST_SDIV, ST_ADDR, ST_ACC, ST_DIVM,
    ST_WAITM, ST_FINISH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    op        = ira_pkg::OP_NONE;
    unique case (state_r)
      ST_IDLE:   if (in_valid && in_fetch) state_nxt = ST_GEO0;
      ST_GEO0:   begin op = ira_pkg::OP_GEO0; state_nxt = ST_GEO1; end
      ST_GEO1:   begin op = ira_pkg::OP_GEO1; state_nxt = ST_GEO2; end
      ST_GEO2:   begin op = ira_pkg::OP_GEO2; state_nxt = ST_DIVW; end
      ST_DIVW:   begin op = ira_pkg::OP_DIVW; state_nxt = ST_WAITW; end
      ST_WAITW:  if (stat.div_done) state_nxt = ST_DIVH;
      ST_DIVH:   begin op = ira_pkg::OP_DIVH; state_nxt = ST_WAITH; end
      ST_WAITH:  if (stat.div_done) state_nxt = ST_CHECK;
      ST_CHECK:  begin
        op        = ira_pkg::OP_CHECK;
        state_nxt = stat.fetch_ok ? ST_INIT : ST_FINISH;
      end
      ST_INIT:   begin op = ira_pkg::OP_INIT; state_nxt = ST_MUL; end
      ST_MUL:    begin op = ira_pkg::OP_MUL; state_nxt = ST_XY; end
      ST_XY:     begin op = ira_pkg::OP_XY; state_nxt = ST_SDIV; end
      ST_SDIV:   begin op = ira_pkg::OP_SDIV; state_nxt = ST_ADDR; end
      ST_ADDR:   state_nxt = ST_ACC;
      ST_ACC:    begin
        op        = ira_pkg::OP_ACC;
        state_nxt = stat.last_sample ? ST_DIVM : ST_MUL;
      end
      ST_DIVM:   begin op = ira_pkg::OP_DIVM; state_nxt = ST_WAITM; end
      ST_WAITM:  if (stat.div_done) state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (stat.out_free) begin
          op        = ira_pkg::OP_PUBLISH;
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

endmodule

// ===== rtl/image_rotate_nearest_resample.sv =====
// Top level of the nearest-neighbour image rotator with box downsampling.
// A load transaction writes the source store directly.
// A fetch runs geometry (three steps, two divisions and a range check), then the
// d-by-d box, the mean and a publish step that waits for a free output register;
// a fetch outside the output grid skips box and mean. One item at a time.
// Reset is synchronous, active low; the source store is not cleared.
module image_rotate_nearest_resample (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // pixel_in[15:0], load_col[23:16], load_row[31:24], fetch_col[44:32],
  // fetch_row[57:45], zero fill above
  input  logic [63:0] in_tdata,
  // action[0]: 0 load, 1 fetch
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // pixel_out[15:0], in_range[16], out_width[29:17], out_height[42:30],
  // zero fill above
  output logic [47:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  // Configuration register file. Writes are taken in every cycle; the user
  // only writes while the block is idle.
  ira_pkg::cfg_t     cfg_r;
  ira_pkg::dp_op_t   op;
  ira_pkg::dp_stat_t stat;
  logic              in_accept;
  logic              ram_we;
  logic [ira_pkg::ADDR_BITS-1:0]  ram_raddr;
  logic [ira_pkg::PIXEL_BITS-1:0] ram_rdata;
  logic [15:0]       out_pixel;
  logic              out_in_range;
  logic [12:0]       out_width, out_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_w  <= 9'd256;
      cfg_r.src_h  <= 9'd256;
      cfg_r.sine   <= 17'sd0;
      cfg_r.cosine <= 17'd65536;
      cfg_r.up     <= 4'd1;
      cfg_r.down   <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ira_pkg::CFG_SOURCE_WIDTH:  cfg_r.src_w  <= cfg_data[8:0];
        ira_pkg::CFG_SOURCE_HEIGHT: cfg_r.src_h  <= cfg_data[8:0];
        ira_pkg::CFG_SINE:          cfg_r.sine   <= signed'(cfg_data);
        ira_pkg::CFG_COSINE:        cfg_r.cosine <= cfg_data;
        ira_pkg::CFG_UPSAMPLE:      cfg_r.up     <= cfg_data[3:0];
        ira_pkg::CFG_DOWNSAMPLE:    cfg_r.down   <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  assign in_accept = in_tvalid && in_tready;
  // A load transaction writes its pixel at row-major address {row, col}.
  assign ram_we    = in_accept && !in_tuser[0];

  ira_ram #(
    .WIDTH (ira_pkg::PIXEL_BITS),
    .DEPTH (ira_pkg::MAX_SIDE * ira_pkg::MAX_SIDE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({in_tdata[31:24], in_tdata[23:16]}),
    .wdata (in_tdata[15:0]),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ira_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_fetch (in_tuser[0]),
    .in_ready (in_tready),
    .stat     (stat),
    .op       (op)
  );

  ira_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .op           (op),
    .stat         (stat),
    .cfg          (cfg_r),
    .in_accept    (in_accept),
    .fetch_col    (in_tdata[44:32]),
    .fetch_row    (in_tdata[57:45]),
    .ram_rdata    (ram_rdata),
    .ram_raddr    (ram_raddr),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_pixel    (out_pixel),
    .out_in_range (out_in_range),
    .out_width    (out_width),
    .out_height   (out_height)
  );

  // The result sits in an output register until its transaction completes.
  assign out_tdata = {5'd0, out_height, out_width, out_in_range, out_pixel};

endmodule

// ===== rtl/ira_chk.sv =====
// Port-level checker for the image rotate resampler, bound to the top level.
module ira_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[16] |-> out_tdata[15:0] == 16'd0)
    else $error("fetch outside image gave nonzero pixel");

  a_fetch_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] |=> !in_tready)
    else $error("input ready right after a fetch");

endmodule

bind image_rotate_nearest_resample ira_chk u_chk (.*);
